/* design/gfpse_pkg.sv */
// ----------------------------------------------------------------------------
// gfpse_pkg: shared types and tables for the GF(2^8) packed sharing engine
// Field arithmetic over the AES field (x^8+x^4+x^3+x+1), the fixed
// encoding, decoding and zero-encoding coefficient tables, and the
// per-lane coefficient select.
// ----------------------------------------------------------------------------
package gfpse_pkg;

  localparam int NUM_PARTIES = 7;
  localparam int NUM_PROBES  = 3;
  localparam int NUM_SECRETS = 3;
  localparam int NUM_POINTS  = NUM_PROBES + 1;

  // Operation codes
  localparam logic [1:0] OP_SHARE = 2'd0;
  localparam logic [1:0] OP_RECON = 2'd1;
  localparam logic [1:0] OP_ZENC  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Low byte of the reduction polynomial
  localparam logic [7:0] GF_POLY_LO = 8'h1B;

  typedef logic [7:0] byte_t;
  typedef logic [NUM_PARTIES-1:0][7:0] vec_t;

  // Control word travelling with the lane products
  typedef struct packed {
    logic       valid;
  } ctl_t;

  localparam byte_t ENC_MAT [0:NUM_POINTS-1][0:NUM_PARTIES-1] = '{
    '{8'hA5, 8'hF5, 8'h02, 8'h2C, 8'hDC, 8'h86, 8'h24},
    '{8'hF5, 8'h07, 8'h04, 8'h62, 8'h68, 8'h84, 8'h78},
    '{8'h02, 8'h04, 8'h6E, 8'h44, 8'h21, 8'h58, 8'h55},
    '{8'h53, 8'hF7, 8'h69, 8'h0B, 8'h94, 8'h5B, 8'h08}
  };

  localparam byte_t DEC_MAT [0:NUM_PARTIES-1][0:NUM_POINTS-1] = '{
    '{8'hE0, 8'h0F, 8'h02, 8'h9C},
    '{8'h77, 8'hE7, 8'h92, 8'h85},
    '{8'hA5, 8'h2C, 8'h38, 8'h7B},
    '{8'h55, 8'h4F, 8'h74, 8'hA8},
    '{8'h4A, 8'h41, 8'h78, 8'hAC},
    '{8'h8E, 8'hE4, 8'h53, 8'hA7},
    '{8'hA2, 8'h2F, 8'hF6, 8'hC0}
  };

  localparam byte_t ZENC_VEC [0:NUM_PARTIES-1] = '{
    8'h01, 8'h8C, 8'hB8, 8'h4F, 8'hB1, 8'h0B, 8'h0A
  };

  // GF(2^8) product, shift-and-add with reduction per step
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t x;
    byte_t acc;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LO : 8'h00);
    end
    return acc;
  endfunction

  // Coefficient applied to input byte j for output lane l; zero where the
  // operation does not use that input or lane (also for the unused code)
  function automatic byte_t coef_sel(input logic [1:0] op, input int l, input int j);
    byte_t c;
    c = 8'h00;
    case (op)
      OP_SHARE: begin
        if (j < NUM_POINTS) c = ENC_MAT[j][l];
      end
      OP_RECON: begin
        if (l < NUM_SECRETS) c = DEC_MAT[j][l];
      end
      OP_ZENC: begin
        if (j == 0) c = ZENC_VEC[l];
      end
      default: begin
        c = 8'h00;
      end
    endcase
    return c;
  endfunction

endpackage

/* design/gfpse_lane.sv */
// ----------------------------------------------------------------------------
// gfpse_lane: one output column of the sharing engine
// Multiplies each of the seven input bytes by its selected coefficient.
// ----------------------------------------------------------------------------
module gfpse_lane (
  input  gfpse_pkg::vec_t vals_i,
  input  gfpse_pkg::vec_t coefs_i,
  output gfpse_pkg::vec_t prods_o
);

  // One field multiplier per input byte
  always_comb begin
    for (int j = 0; j < gfpse_pkg::NUM_PARTIES; j++) begin
      prods_o[j] = gfpse_pkg::gf_mul(vals_i[j], coefs_i[j]);
    end
  end

endmodule

/* design/gfpse_merge.sv */
// ----------------------------------------------------------------------------
// gfpse_merge: lane merge and result register
// XOR-reduces each lane's products into its output byte and registers the
// result word together with its strobe.
// ----------------------------------------------------------------------------
module gfpse_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gfpse_pkg::ctl_t  ctl_i,
  input  gfpse_pkg::vec_t  prods_i [gfpse_pkg::NUM_PARTIES],
  output logic             done_o,
  output gfpse_pkg::vec_t  result_o
);

  logic            valid_q;
  gfpse_pkg::vec_t result_d, result_q;

  // XOR sum per lane
  always_comb begin
    for (int l = 0; l < gfpse_pkg::NUM_PARTIES; l++) begin
      result_d[l] = 8'h00;
      for (int j = 0; j < gfpse_pkg::NUM_PARTIES; j++) begin
        result_d[l] = result_d[l] ^ prods_i[l][j];
      end
    end
  end

  // Strobe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  // Result word register, loaded on accepted words only
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      result_q <= result_d;
    end
  end

  assign done_o   = valid_q;
  assign result_o = result_q;

endmodule

/* design/gf256_packed_share_encode_decode.sv */
// ----------------------------------------------------------------------------
// gf256_packed_share_encode_decode: packed secret sharing over GF(2^8)
// Timing: result and done_o are registered; a word accepted at an edge shows
//   its result with done_o for exactly one cycle, in the cycle after that edge.
// Throughput: one word per cycle, set by the single merge register stage;
//   busy stays low, the receiver cannot stall.
// Reset: asynchronous active low, clears the result strobe only.
// ----------------------------------------------------------------------------
module gf256_packed_share_encode_decode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] in_0_i,
  input  logic [7:0] in_1_i,
  input  logic [7:0] in_2_i,
  input  logic [7:0] in_3_i,
  input  logic [7:0] in_4_i,
  input  logic [7:0] in_5_i,
  input  logic [7:0] in_6_i,
  output logic       done_o,
  output logic [7:0] out_0_o,
  output logic [7:0] out_1_o,
  output logic [7:0] out_2_o,
  output logic [7:0] out_3_o,
  output logic [7:0] out_4_o,
  output logic [7:0] out_5_o,
  output logic [7:0] out_6_o
);

  gfpse_pkg::vec_t vals;
  gfpse_pkg::vec_t coefs [gfpse_pkg::NUM_PARTIES];
  gfpse_pkg::vec_t prods [gfpse_pkg::NUM_PARTIES];
  gfpse_pkg::vec_t result;
  gfpse_pkg::ctl_t ctl;

  // No back-pressure anywhere
  assign busy = 1'b0;

  assign vals = {in_6_i, in_5_i, in_4_i, in_3_i, in_2_i, in_1_i, in_0_i};

  assign ctl.valid = start & ~busy;

  // Lanes: one per output byte
  for (genvar l = 0; l < gfpse_pkg::NUM_PARTIES; l++) begin : g_lane
    always_comb begin
      for (int j = 0; j < gfpse_pkg::NUM_PARTIES; j++) begin
        coefs[l][j] = gfpse_pkg::coef_sel(operation_i, l, j);
      end
    end

    gfpse_lane u_lane (
      .vals_i  (vals),
      .coefs_i (coefs[l]),
      .prods_o (prods[l])
    );
  end

  gfpse_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .prods_i  (prods),
    .done_o   (done_o),
    .result_o (result)
  );

  assign out_0_o = result[0];
  assign out_1_o = result[1];
  assign out_2_o = result[2];
  assign out_3_o = result[3];
  assign out_4_o = result[4];
  assign out_5_o = result[5];
  assign out_6_o = result[6];

  // Each accepted word yields exactly one strobe, in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted word produced no result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result strobe without an accepted word");

  // Reconstruct leaves the share-only outputs at zero
  a_recon_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && operation_i == gfpse_pkg::OP_RECON) |=>
      (out_3_o == 8'h00 && out_4_o == 8'h00 && out_5_o == 8'h00 && out_6_o == 8'h00))
    else $error("reconstruct left nonzero share outputs");

  // Zero encode passes the random byte through in share 0
  a_zenc_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && operation_i == gfpse_pkg::OP_ZENC) |=> (out_0_o == $past(in_0_i)))
    else $error("zero encode share 0 differs from random byte");

  // The unused selector gives an all-zero word
  a_nop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && operation_i == gfpse_pkg::OP_NONE) |=> (result == '0))
    else $error("unused selector produced nonzero result");

endmodule

/* tb/gf256_packed_share_encode_decode_test.sv */
// ----------------------------------------------------------------------------
// gf256_packed_share_encode_decode_test: self-checking bench for the engine
// Sends a table of directed words, then about 1200 random words, with
// random idle bursts between them. Every result is checked lane by lane
// against typed expectations or a local GF(2^8) model of share, reconstruct and zero encode.
// ----------------------------------------------------------------------------
module gf256_packed_share_encode_decode_test;
  import gfpse_pkg::*;

  localparam byte_t      REDUCE_LO  = 8'h1B;
  localparam int         NUM_RANDOM = 1200;
  localparam int         TAIL_WORDS = 150;
  localparam int         LIMIT      = 200000;

  // Coefficients: input byte j feeds output lane l
  localparam byte_t SHARE_COEF [NUM_POINTS][NUM_PARTIES] = '{
    '{8'hA5, 8'hF5, 8'h02, 8'h2C, 8'hDC, 8'h86, 8'h24},
    '{8'hF5, 8'h07, 8'h04, 8'h62, 8'h68, 8'h84, 8'h78},
    '{8'h02, 8'h04, 8'h6E, 8'h44, 8'h21, 8'h58, 8'h55},
    '{8'h53, 8'hF7, 8'h69, 8'h0B, 8'h94, 8'h5B, 8'h08}
  };
  localparam byte_t UNSHARE_COEF [NUM_PARTIES][NUM_POINTS] = '{
    '{8'hE0, 8'h0F, 8'h02, 8'h9C},
    '{8'h77, 8'hE7, 8'h92, 8'h85},
    '{8'hA5, 8'h2C, 8'h38, 8'h7B},
    '{8'h55, 8'h4F, 8'h74, 8'hA8},
    '{8'h4A, 8'h41, 8'h78, 8'hAC},
    '{8'h8E, 8'hE4, 8'h53, 8'hA7},
    '{8'hA2, 8'h2F, 8'hF6, 8'hC0}
  };
  localparam byte_t ZERO_COEF [NUM_PARTIES] = '{
    8'h01, 8'h8C, 8'hB8, 8'h4F, 8'hB1, 8'h0B, 8'h0A
  };

  typedef struct {
    logic [1:0] op;
    vec_t       din;
    logic       typed;
    vec_t       want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] operation_i;
  vec_t       din_q;
  logic       done_o;
  vec_t       res;

  // Expectation typed into the table for the word now on the inputs
  logic       typed_row;
  vec_t       typed_want;

  vec_t       pending_results [$];
  stim_row_t  dir_rows [$];
  int         cycles;
  int         errors;
  int         n_checked;
  int         op_seen [4];

  gf256_packed_share_encode_decode u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .in_0_i      (din_q[0]),
    .in_1_i      (din_q[1]),
    .in_2_i      (din_q[2]),
    .in_3_i      (din_q[3]),
    .in_4_i      (din_q[4]),
    .in_5_i      (din_q[5]),
    .in_6_i      (din_q[6]),
    .done_o      (done_o),
    .out_0_o     (res[0]),
    .out_1_o     (res[1]),
    .out_2_o     (res[2]),
    .out_3_o     (res[3]),
    .out_4_o     (res[4]),
    .out_5_o     (res[5]),
    .out_6_o     (res[6])
  );

  always #2 clk_i = ~clk_i;

  // Field product, Horner form over the bits of b (MSB first)
  function automatic byte_t gf_times(input byte_t a, input byte_t b);
    byte_t prod;
    prod = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      prod = {prod[6:0], 1'b0} ^ (prod[7] ? REDUCE_LO : 8'h00);
      if (b[i]) prod = prod ^ a;
    end
    return prod;
  endfunction

  // Expected output lanes for one word
  function automatic vec_t predict_word(input logic [1:0] op, input vec_t din);
    vec_t r;
    r = '0;
    case (op)
      OP_SHARE: begin
        for (int l = 0; l < NUM_PARTIES; l++)
          for (int j = 0; j < NUM_POINTS; j++)
            r[l] = r[l] ^ gf_times(din[j], SHARE_COEF[j][l]);
      end
      OP_RECON: begin
        for (int l = 0; l < NUM_SECRETS; l++)
          for (int j = 0; j < NUM_PARTIES; j++)
            r[l] = r[l] ^ gf_times(din[j], UNSHARE_COEF[j][l]);
      end
      OP_ZENC: begin
        for (int l = 0; l < NUM_PARTIES; l++)
          r[l] = gf_times(din[0], ZERO_COEF[l]);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // Lane 0 first, the way the ports are numbered
  function automatic vec_t v7(input byte_t b0, b1, b2, b3, b4, b5, b6);
    return {b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic stim_row_t row(input logic [1:0] op, input vec_t din,
                                    input logic typed, input vec_t want);
    stim_row_t s;
    s.op    = op;
    s.din   = din;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Biased byte: corners and single bits show up often
  function automatic byte_t rand_byte();
    byte_t b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h01 << $urandom_range(0, 7);
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    for (int l = 0; l < NUM_PARTIES; l++) v[l] = rand_byte();
    return v;
  endfunction

  // Drive one word at the falling edge and hold it until it is taken
  task automatic send_word(input logic [1:0] op, input vec_t din,
                           input logic typed, input vec_t want);
    @(negedge clk_i);
    start       <= 1'b1;
    operation_i <= op;
    din_q       <= din;
    typed_row   <= typed;
    typed_want  <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Start low, junk on the data lines
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start       <= 1'b0;
      operation_i <= 2'($urandom_range(0, 3));
      din_q       <= 56'({$urandom(), $urandom()});
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Scoreboard: check the result on the bus, then log the word taken now
  always @(posedge clk_i) begin
    vec_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %014h", $time, res);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        for (int l = 0; l < NUM_PARTIES; l++) begin
          if (res[l] !== want[l]) begin
            errors++;
            $display("%0t: out_%0d mismatch, expected %02h, got %02h", $time, l,
                     want[l], res[l]);
          end
        end
      end
    end
    if (rst_ni && start && !busy) begin
      op_seen[operation_i]++;
      pending_results.push_back(typed_row ? typed_want : predict_word(operation_i, din_q));
    end
  end

  initial begin
    vec_t last_shares;
    vec_t secrets;
    vec_t din;
    logic [1:0] op;
    int   idle_pct;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = OP_SHARE;
    din_q       = '0;
    typed_row   = 1'b0;
    typed_want  = '0;
    cycles      = 0;
    errors      = 0;
    n_checked   = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    last_shares = '0;

    // Directed words; expectations typed in only where they are obvious
    dir_rows = '{
      row(OP_SHARE, '0, 1'b1, '0),
      row(OP_SHARE, v7(8'h01, 0, 0, 0, 0, 0, 0), 1'b1,
          v7(8'hA5, 8'hF5, 8'h02, 8'h2C, 8'hDC, 8'h86, 8'h24)),
      row(OP_SHARE, v7(0, 0, 0, 8'h01, 0, 0, 0), 1'b1,
          v7(8'h53, 8'hF7, 8'h69, 8'h0B, 8'h94, 8'h5B, 8'h08)),
      row(OP_SHARE, {NUM_PARTIES{8'hFF}}, 1'b0, '0),
      row(OP_SHARE, v7(8'h80, 8'h40, 8'h01, 8'hFF, 8'hAA, 8'h55, 8'hAA), 1'b0, '0),
      row(OP_SHARE, v7(8'hFF, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0),
      row(OP_SHARE, v7(8'h12, 8'h34, 8'h56, 8'h78, 0, 0, 0), 1'b0, '0),
      row(OP_RECON, '0, 1'b1, '0),
      row(OP_RECON, v7(8'h01, 0, 0, 0, 0, 0, 0), 1'b1,
          v7(8'hE0, 8'h0F, 8'h02, 0, 0, 0, 0)),
      row(OP_RECON, v7(0, 0, 0, 0, 0, 0, 8'h01), 1'b1,
          v7(8'hA2, 8'h2F, 8'hF6, 0, 0, 0, 0)),
      row(OP_RECON, {NUM_PARTIES{8'hFF}}, 1'b0, '0),
      row(OP_RECON, v7(8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40), 1'b0, '0),
      row(OP_RECON, v7(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80), 1'b0, '0),
      row(OP_RECON, v7(8'h5A, 8'hC3, 8'h3C, 8'hA5, 8'h0F, 8'hF0, 8'h99), 1'b0, '0),
      row(OP_ZENC, v7(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, '0),
      row(OP_ZENC, v7(8'h01, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55), 1'b1,
          v7(8'h01, 8'h8C, 8'hB8, 8'h4F, 8'hB1, 8'h0B, 8'h0A)),
      row(OP_ZENC, v7(8'hFF, 0, 0, 0, 0, 0, 0), 1'b0, '0),
      row(OP_ZENC, v7(8'h80, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b0, '0),
      row(OP_NONE, {NUM_PARTIES{8'hFF}}, 1'b1, '0),
      row(OP_NONE, v7(8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h33), 1'b1, '0)
    };

    // Reset held from the start, released at a falling edge
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].din, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);
    drain();

    // Random words: mostly real share/reconstruct pairs, some noise
    idle_pct = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          op      = OP_SHARE;
          secrets = rand_vec();
          din     = secrets;
        end
        3, 4: begin
          // genuine shares of the last shared secrets
          op  = OP_RECON;
          din = last_shares;
        end
        5: begin
          // corrupted shares
          op  = OP_RECON;
          din = last_shares;
          din[$urandom_range(0, NUM_PARTIES - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end
        6: begin
          op  = OP_RECON;
          din = rand_vec();
        end
        7, 8: begin
          op  = OP_ZENC;
          din = rand_vec();
        end
        default: begin
          op  = OP_NONE;
          din = rand_vec();
        end
      endcase
      if (op == OP_SHARE) last_shares = predict_word(OP_SHARE, din);
      send_word(op, din, 1'b0, '0);

      // hold off until the pipe is empty now and then
      if (n % 300 == 150 && n < NUM_RANDOM - TAIL_WORDS) begin
        idle_cycles(1);
        drain();
      end
      if (n < NUM_RANDOM - TAIL_WORDS && $urandom_range(1, 100) <= idle_pct)
        idle_cycles($urandom_range(1, 8));
    end

    @(negedge clk_i);
    start <= 1'b0;
    drain();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d share, %0d reconstruct, %0d zero-encode, %0d unused-code words",
             op_seen[OP_SHARE], op_seen[OP_RECON], op_seen[OP_ZENC], op_seen[OP_NONE]);
    $display("Checked %0d results lane by lane, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
